[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the console checker. Each macro expects a clock
// named clk in its scope; TCLE_ASSERT_CLK also needs an active-low rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TCLE_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define TCLE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tcle_pkg.sv]
// ----------------------------------------------------------------------------
// tcle_pkg
// Geometry, character codes and controller/datapath types for the console.
// ----------------------------------------------------------------------------
package tcle_pkg;

  localparam int SCREEN_ROWS = 32;
  localparam int SCREEN_COLS = 64;
  localparam int MAX_COMMAND = 126;
  localparam int TAB_STOP    = 4;
  localparam int BUF_DEPTH   = MAX_COMMAND + 2;
  localparam int SCREEN_CELLS = SCREEN_ROWS * SCREEN_COLS;

  localparam int FUNC_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int ROW_W    = $clog2(SCREEN_ROWS);
  localparam int COL_W    = $clog2(SCREEN_COLS);
  localparam int CURCOL_W = $clog2(SCREEN_COLS + 1);
  localparam int CNT_W    = $clog2(MAX_COMMAND + 1);
  localparam int BUF_AW   = $clog2(BUF_DEPTH);
  localparam int CELL_AW  = $clog2(SCREEN_CELLS);

  localparam int IN_FIELDS_W  = CHAR_W + ROW_W + COL_W + BUF_AW;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CHAR_W + ROW_W + CURCOL_W + CNT_W + 1 + CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Bit positions of the result fields inside out_tdata.
  localparam int OUT_ROW_LSB = CHAR_W;
  localparam int OUT_COL_LSB = OUT_ROW_LSB + ROW_W;
  localparam int OUT_CNT_LSB = OUT_COL_LSB + CURCOL_W;
  localparam int OUT_RDY_BIT = OUT_CNT_LSB + CNT_W;
  localparam int OUT_LEN_LSB = OUT_RDY_BIT + 1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'd27;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PRINT     = 3'd0,
    FUNC_KEY       = 3'd1,
    FUNC_READ_CELL = 3'd2,
    FUNC_READ_CMD  = 3'd3,
    FUNC_PROMPT    = 3'd4
  } tcle_func_t;

  // Class of an incoming item, resolved against the current cursor and edit state.
  typedef enum logic [3:0] {
    K_NONE,
    K_NEWLINE,
    K_PRINT_WRAP,
    K_PRINT,
    K_TAB,
    K_ENTER,
    K_BACKSPACE,
    K_APPEND,
    K_READ,
    K_PROMPT
  } tcle_kind_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_NEWLINE,
    ST_CLEAR,
    ST_PROMPT0,
    ST_PROMPT1,
    ST_PUT,
    ST_PUT_ZERO,
    ST_TAB,
    ST_BACKSPACE,
    ST_READ,
    ST_DONE
  } tcle_state_t;

  typedef struct packed {
    logic capture;
    logic clr_start;
    logic clr_step;
    logic init_wr;
    logic row_wr;
    logic newline;
    logic prompt0;
    logic prompt1;
    logic put;
    logic put_zero;
    logic buf_too;
    logic tab;
    logic backspace;
    logic load_out;
  } tcle_cmd_t;

  typedef struct packed {
    tcle_kind_t kind;
    logic       init_last;
    logic       row_last;
    logic       tab_last;
  } tcle_sts_t;

endpackage

[rtl/core/tcle_datapath.sv]
// ----------------------------------------------------------------------------
// tcle_datapath
// Screen and command memories, cursor and edit registers, and the result
// register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module tcle_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tcle_pkg::tcle_cmd_t             cmd,
  output tcle_pkg::tcle_sts_t             sts,
  input  logic [tcle_pkg::FUNC_W-1:0]     in_func,
  input  logic [tcle_pkg::CHAR_W-1:0]     in_char,
  input  logic [tcle_pkg::ROW_W-1:0]      in_row,
  input  logic [tcle_pkg::COL_W-1:0]      in_col,
  input  logic [tcle_pkg::BUF_AW-1:0]     in_index,
  output logic [tcle_pkg::CHAR_W-1:0]     res_read_data,
  output logic [tcle_pkg::ROW_W-1:0]      res_cursor_row,
  output logic [tcle_pkg::CURCOL_W-1:0]   res_cursor_col,
  output logic [tcle_pkg::CNT_W-1:0]      res_edit_length,
  output logic                            res_command_ready,
  output logic [tcle_pkg::CNT_W-1:0]      res_command_length
);
  import tcle_pkg::*;

  logic [CHAR_W-1:0] scr_mem [SCREEN_CELLS];
  logic [CHAR_W-1:0] buf_mem [BUF_DEPTH];

  logic [ROW_W-1:0]    top_r, top_nxt;
  logic [ROW_W-1:0]    line_r, line_nxt;
  logic [CURCOL_W-1:0] curcol_r, curcol_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CELL_AW-1:0]  clr_cnt_r, clr_cnt_nxt;

  logic [CHAR_W-1:0] code_r;
  logic [ROW_W-1:0]  rrow_r;
  logic [COL_W-1:0]  rcol_r;
  logic [BUF_AW-1:0] ridx_r;
  logic [FUNC_W-1:0] func_r;
  logic              ready_r;
  logic [CNT_W-1:0]  len_r;

  logic [CHAR_W-1:0] scr_q_r;
  logic [CHAR_W-1:0] buf_q_r;

  logic [CHAR_W-1:0]   o_data_r;
  logic [ROW_W-1:0]    o_row_r;
  logic [CURCOL_W-1:0] o_col_r;
  logic [CNT_W-1:0]    o_cnt_r;
  logic                o_ready_r;
  logic [CNT_W-1:0]    o_len_r;

  tcle_kind_t kind;
  logic       col_in_row;
  logic       enter_ready;

  logic [ROW_W:0]     line_sum, rd_sum;
  logic [ROW_W-1:0]   line_phys, rd_phys, top_inc;
  logic [CURCOL_W:0]  col_plus1;

  logic                scr_we;
  logic [COL_W-1:0]    scr_wcol;
  logic [CHAR_W-1:0]   scr_wdata;
  logic [CELL_AW-1:0]  scr_waddr, scr_raddr;

  logic                buf_we;
  logic [BUF_AW-1:0]   buf_waddr;
  logic [CHAR_W-1:0]   buf_wdata;

  // Logical rows map onto the ring of physical rows through the top-row offset.
  assign line_sum  = {1'b0, top_r} + {1'b0, line_r};
  assign line_phys = (line_sum >= (ROW_W+1)'(SCREEN_ROWS)) ?
                     ROW_W'(line_sum - (ROW_W+1)'(SCREEN_ROWS)) : ROW_W'(line_sum);
  assign rd_sum    = {1'b0, top_r} + {1'b0, rrow_r};
  assign rd_phys   = (rd_sum >= (ROW_W+1)'(SCREEN_ROWS)) ?
                     ROW_W'(rd_sum - (ROW_W+1)'(SCREEN_ROWS)) : ROW_W'(rd_sum);
  assign top_inc   = (top_r == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top_r + 1'b1;

  assign col_in_row  = (curcol_r < CURCOL_W'(SCREEN_COLS));
  assign col_plus1   = {1'b0, curcol_r} + (CURCOL_W+1)'(1);
  assign enter_ready = (cnt_r != '0);

  // Classify the item on the input port against the present state.
  always_comb begin
    kind = K_NONE;
    case (in_func)
      FUNC_PRINT: begin
        case (in_char) inside
          CH_LF, CH_CR: kind = K_NEWLINE;
          CH_TAB:       kind = K_TAB;
          [CH_SPACE:CH_DEL]: kind = col_in_row ? K_PRINT : K_PRINT_WRAP;
          default:      kind = K_NONE;
        endcase
      end
      FUNC_KEY: begin
        case (in_char) inside
          CH_NUL, CH_ESC: kind = K_NONE;
          CH_LF, CH_CR:   kind = K_ENTER;
          CH_BS, CH_DEL:  kind = enter_ready ? K_BACKSPACE : K_NONE;
          default: begin
            if ((cnt_r < CNT_W'(MAX_COMMAND)) &&
                (col_plus1 < (CURCOL_W+1)'(SCREEN_COLS))) begin
              kind = K_APPEND;
            end else begin
              kind = K_NONE;
            end
          end
        endcase
      end
      FUNC_READ_CELL, FUNC_READ_CMD: kind = K_READ;
      FUNC_PROMPT:                   kind = K_PROMPT;
      default:                       kind = K_NONE;
    endcase
  end

  assign sts.kind      = kind;
  assign sts.init_last = (clr_cnt_r == CELL_AW'(SCREEN_CELLS - 1));
  assign sts.row_last  = (clr_cnt_r[COL_W-1:0] == COL_W'(SCREEN_COLS - 1));
  // A tab stops after the cell that lands the cursor on a stop or at the row end.
  assign sts.tab_last  = (curcol_r >= CURCOL_W'(SCREEN_COLS - 1)) ||
                         ((col_plus1 % TAB_STOP) == '0);

  // Screen write port.
  always_comb begin
    scr_we    = 1'b0;
    scr_wcol  = curcol_r[COL_W-1:0];
    scr_wdata = '0;
    if (cmd.row_wr) begin
      scr_we   = 1'b1;
      scr_wcol = clr_cnt_r[COL_W-1:0];
    end else if (cmd.prompt0) begin
      scr_we    = 1'b1;
      scr_wcol  = '0;
      scr_wdata = CH_GT;
    end else if (cmd.prompt1) begin
      scr_we    = 1'b1;
      scr_wcol  = COL_W'(1);
      scr_wdata = CH_SPACE;
    end else if (cmd.put) begin
      scr_we    = col_in_row;
      scr_wdata = code_r;
    end else if (cmd.put_zero) begin
      scr_we = col_in_row;
    end else if (cmd.tab) begin
      scr_we    = col_in_row;
      scr_wdata = CH_SPACE;
    end else if (cmd.backspace) begin
      scr_we   = enter_ready && (curcol_r > CURCOL_W'(2));
      scr_wcol = COL_W'(curcol_r - CURCOL_W'(1));
    end
  end

  assign scr_waddr = cmd.init_wr ? clr_cnt_r :
                     CELL_AW'(CELL_AW'(line_phys) * CELL_AW'(SCREEN_COLS) +
                              CELL_AW'(scr_wcol));
  assign scr_raddr = CELL_AW'(CELL_AW'(rd_phys) * CELL_AW'(SCREEN_COLS) +
                              CELL_AW'(rcol_r));

  always_ff @(posedge clk) begin
    if (scr_we || cmd.init_wr) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    scr_q_r <= scr_mem[scr_raddr];
  end

  // Command buffer write port.
  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = BUF_AW'(cnt_r);
    buf_wdata = '0;
    if (cmd.put && cmd.buf_too) begin
      buf_we    = 1'b1;
      buf_wdata = code_r;
    end else if (cmd.put_zero && cmd.buf_too) begin
      buf_we = 1'b1;
    end else if (cmd.backspace) begin
      buf_we    = enter_ready;
      buf_waddr = BUF_AW'(cnt_r - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    buf_q_r <= buf_mem[ridx_r];
  end

  // Cursor, scroll offset, edit count and clear counter.
  always_comb begin
    top_nxt     = top_r;
    line_nxt    = line_r;
    curcol_nxt  = curcol_r;
    cnt_nxt     = cnt_r;
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.clr_start) begin
      clr_cnt_nxt = '0;
    end else if (cmd.clr_step) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
    if (cmd.newline) begin
      curcol_nxt = '0;
      if (line_r == ROW_W'(SCREEN_ROWS - 1)) begin
        top_nxt = top_inc;
      end else begin
        line_nxt = line_r + 1'b1;
      end
    end
    if (cmd.prompt1) begin
      curcol_nxt = CURCOL_W'(2);
      cnt_nxt    = '0;
    end
    if ((cmd.put || cmd.tab) && col_in_row) begin
      curcol_nxt = CURCOL_W'(col_plus1);
    end
    if (cmd.put && cmd.buf_too) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.backspace && enter_ready) begin
      cnt_nxt = cnt_r - 1'b1;
      if (curcol_r > CURCOL_W'(2)) begin
        curcol_nxt = curcol_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r     <= '0;
      line_r    <= '0;
      curcol_r  <= '0;
      cnt_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      top_r     <= top_nxt;
      line_r    <= line_nxt;
      curcol_r  <= curcol_nxt;
      cnt_r     <= cnt_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Item fields held for the whole transaction.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_r  <= in_char;
      rrow_r  <= in_row;
      rcol_r  <= in_col;
      ridx_r  <= in_index;
      func_r  <= in_func;
      ready_r <= (kind == K_ENTER) && enter_ready;
      len_r   <= ((kind == K_ENTER) && enter_ready) ? cnt_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (func_r == FUNC_READ_CELL) begin
        o_data_r <= scr_q_r;
      end else if (func_r == FUNC_READ_CMD) begin
        o_data_r <= buf_q_r;
      end else begin
        o_data_r <= '0;
      end
      o_row_r   <= line_r;
      o_col_r   <= curcol_r;
      o_cnt_r   <= cnt_r;
      o_ready_r <= ready_r;
      o_len_r   <= len_r;
    end
  end

  assign res_read_data      = o_data_r;
  assign res_cursor_row     = o_row_r;
  assign res_cursor_col     = o_col_r;
  assign res_edit_length    = o_cnt_r;
  assign res_command_ready  = o_ready_r;
  assign res_command_length = o_len_r;

endmodule

[rtl/core/tcle_ctrl.sv]
// ----------------------------------------------------------------------------
// tcle_ctrl
// Sequencer for the console: clearing pass, per-item step sequence and the
// result handshake.
// ----------------------------------------------------------------------------
module tcle_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  tcle_pkg::tcle_sts_t  sts,
  output tcle_pkg::tcle_cmd_t  cmd
);
  import tcle_pkg::*;

  tcle_state_t state_r, state_nxt;
  tcle_kind_t  kind_r, kind_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;
  logic        out_free;

  assign accept   = (state_r == ST_IDLE) && in_tvalid;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    unique case (state_r)
      ST_INIT: begin
        if (sts.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          kind_nxt = sts.kind;
          unique case (sts.kind)
            K_NEWLINE, K_PRINT_WRAP, K_ENTER: state_nxt = ST_NEWLINE;
            K_PRINT, K_APPEND:                state_nxt = ST_PUT;
            K_TAB:                            state_nxt = ST_TAB;
            K_BACKSPACE:                      state_nxt = ST_BACKSPACE;
            K_READ:                           state_nxt = ST_READ;
            K_PROMPT:                         state_nxt = ST_CLEAR;
            default:                          state_nxt = ST_DONE;
          endcase
        end
      end
      ST_NEWLINE: state_nxt = ST_CLEAR;
      ST_CLEAR: begin
        if (sts.row_last) begin
          if ((kind_r == K_ENTER) || (kind_r == K_PROMPT)) begin
            state_nxt = ST_PROMPT0;
          end else if (kind_r == K_PRINT_WRAP) begin
            state_nxt = ST_PUT;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PROMPT0:   state_nxt = ST_PROMPT1;
      ST_PROMPT1:   state_nxt = ST_DONE;
      ST_PUT:       state_nxt = ST_PUT_ZERO;
      ST_PUT_ZERO:  state_nxt = ST_DONE;
      ST_TAB: begin
        if (sts.tab_last) state_nxt = ST_DONE;
      end
      ST_BACKSPACE: state_nxt = ST_DONE;
      ST_READ:      state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_INIT: begin
        cmd.init_wr  = 1'b1;
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        cmd.capture   = accept;
        cmd.clr_start = accept;
      end
      ST_NEWLINE: cmd.newline = 1'b1;
      ST_CLEAR: begin
        cmd.row_wr   = 1'b1;
        cmd.clr_step = 1'b1;
      end
      ST_PROMPT0: cmd.prompt0 = 1'b1;
      ST_PROMPT1: cmd.prompt1 = 1'b1;
      ST_PUT: begin
        cmd.put     = 1'b1;
        cmd.buf_too = (kind_r == K_APPEND);
      end
      ST_PUT_ZERO: begin
        cmd.put_zero = 1'b1;
        cmd.buf_too  = (kind_r == K_APPEND);
      end
      ST_TAB:       cmd.tab = 1'b1;
      ST_BACKSPACE: cmd.backspace = 1'b1;
      ST_READ:      cmd = '0;
      ST_DONE: begin
        cmd.load_out = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default:      cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      kind_r      <= K_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

[rtl/core/text_console_line_editor.sv]
// ----------------------------------------------------------------------------
// text_console_line_editor
// Character-cell console of 32 rows by 64 columns with a one-line command
// editor behind a "> " prompt.
//
// Usage:
// - Items enter on the in_ stream; in_tuser selects the function (print, key,
//   read cell, read command byte, prompt). Every item gives exactly one result
//   on the out_ stream with the cursor, edit length and command status.
// - One item at a time. An ignored code or spare function goes straight to its
//   result; a read or backspace takes one step; a printed byte or edited key
//   writes the byte, then a zero. A tab pads to the next stop or the row end.
//   A new line clears its row one cell per cycle; a prompt, Enter or a wrapping
//   byte clears it too. The next item is taken in the cycle after the result loads.
// - After reset the block sweeps the 2048-cell screen memory to zero, one cell
//   per cycle, and holds in_tready low until the sweep is done.
// - The result sits in an output register. While the receiver stalls, the next
//   item is still accepted and processed; only its result waits until the
//   register is taken.
// ----------------------------------------------------------------------------
module text_console_line_editor (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input item.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0 up: char_code[7:0], read_row[12:8], read_col[18:13],
  // read_index[25:19], zero pad.
  input  logic [tcle_pkg::IN_DATA_W-1:0]    in_tdata,
  // Fields: func[2:0].
  input  logic [tcle_pkg::FUNC_W-1:0]       in_tuser,
  // Result item.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0 up: read_data[7:0], cursor_row[12:8], cursor_col[19:13],
  // edit_length[26:20], command_ready[27], command_length[34:28], zero pad.
  output logic [tcle_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import tcle_pkg::*;

  tcle_cmd_t cmd;
  tcle_sts_t sts;

  logic [CHAR_W-1:0]   res_read_data;
  logic [ROW_W-1:0]    res_cursor_row;
  logic [CURCOL_W-1:0] res_cursor_col;
  logic [CNT_W-1:0]    res_edit_length;
  logic                res_command_ready;
  logic [CNT_W-1:0]    res_command_length;

  // The controller sequences the steps of each transaction and owns both
  // handshakes; the datapath holds the memories and the data registers.
  tcle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tcle_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_tuser),
    .in_char            (in_tdata[CHAR_W-1:0]),
    .in_row             (in_tdata[CHAR_W +: ROW_W]),
    .in_col             (in_tdata[CHAR_W+ROW_W +: COL_W]),
    .in_index           (in_tdata[CHAR_W+ROW_W+COL_W +: BUF_AW]),
    .res_read_data      (res_read_data),
    .res_cursor_row     (res_cursor_row),
    .res_cursor_col     (res_cursor_col),
    .res_edit_length    (res_edit_length),
    .res_command_ready  (res_command_ready),
    .res_command_length (res_command_length)
  );

  // Pack the result fields, lowest field first, zero-extended to whole bytes.
  assign out_tdata = OUT_DATA_W'({res_command_length, res_command_ready,
                                  res_edit_length, res_cursor_col,
                                  res_cursor_row, res_read_data});

endmodule

[rtl/core/tcle_checker.sv]
// ----------------------------------------------------------------------------
// tcle_checker
// Port-level checks on the console: result stability, field ranges, command
// status consistency and the reset sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcle_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [tcle_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic [tcle_pkg::FUNC_W-1:0]       in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tcle_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import tcle_pkg::*;

  logic [CURCOL_W-1:0] chk_col;
  logic [CNT_W-1:0]    chk_cnt;
  logic                chk_rdy;
  logic [CNT_W-1:0]    chk_len;

  assign chk_col     = out_tdata[OUT_COL_LSB +: CURCOL_W];
  assign chk_cnt     = out_tdata[OUT_CNT_LSB +: CNT_W];
  assign chk_rdy     = out_tdata[OUT_RDY_BIT];
  assign chk_len     = out_tdata[OUT_LEN_LSB +: CNT_W];

  // A stalled result keeps its payload.
  `TCLE_ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // The cursor never goes past the row end and the line never past its limit.
  `TCLE_ASSERT_CLK(a_ranges, out_tvalid |-> (chk_col <= CURCOL_W'(SCREEN_COLS)) && (chk_cnt <= CNT_W'(MAX_COMMAND)), "cursor or edit length out of range")

  // A submitted command has a length and clears the edit line; no length otherwise.
  `TCLE_ASSERT_CLK(a_cmd_status, out_tvalid && chk_rdy |-> (chk_len != '0) && (chk_cnt == '0) && (chk_col == CURCOL_W'(2)), "submitted command status inconsistent")
  `TCLE_ASSERT_CLK(a_cmd_len_zero, out_tvalid && !chk_rdy |-> (chk_len == '0), "command length without submit")

  // Reset starts the screen sweep: no input taken and no result shown.
  `TCLE_ASSERT_RST(a_reset_sweep, !rst_n |=> !in_tready && !out_tvalid, "block active right after reset")

endmodule

bind text_console_line_editor tcle_checker u_tcle_checker (.*);

[tb/text_console_line_editor_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_line_editor_tb
// Self-checking bench for the character-cell console with its prompt line
// editor. Every input transaction updates a behavioral copy of the screen,
// the cursor and the command buffer. The copy predicts one status word, and
// each status word that leaves the block is checked field by field against
// the oldest prediction. The stimulus starts with a short directed pass.
// It then runs random prompt sessions, printed text with tabs, wraps and
// scrolls, a command filled to its maximum length, and unstructured noise.
// ----------------------------------------------------------------------------
module text_console_line_editor_tb;
  import tcle_pkg::*;

  localparam int          TOTAL_ITEMS   = 800;
  localparam int          SETTLE_CYCLES = 100;    // longer than the slowest item (Enter)
  localparam int unsigned TIMEOUT_NS    = 5_000_000;

  // Function codes with no operation behind them.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_PROMPT + 1;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = '1;

  // One status word as it appears in out_tdata, read_data in the lowest bits.
  typedef struct packed {
    logic [CNT_W-1:0]    cmd_len;
    logic                cmd_ready;
    logic [CNT_W-1:0]    edit_len;
    logic [CURCOL_W-1:0] col;
    logic [ROW_W-1:0]    row;
    logic [CHAR_W-1:0]   data;
  } console_status_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  text_console_line_editor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Behavioral copy of the console. Rows are kept as a ring: top_row is the
  // physical row that is shown as logical row 0.
  bit [CHAR_W-1:0] screen_mem [SCREEN_CELLS];
  bit [CHAR_W-1:0] cmd_buf    [BUF_DEPTH];
  bit              cmd_written[BUF_DEPTH];
  int              top_row, cur_line, cur_col, edit_cnt;

  console_status_t status_due[$];

  // Knobs shared by the sender, the receiver and the test tasks.
  bit src_idle_en   = 1'b1;
  bit sink_idle_en  = 1'b1;
  int sink_hold_req = 0;
  bit sink_in_hold  = 1'b0;

  // Run statistics.
  int mismatch_count = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int useful_count   = 0;
  int commands_done  = 0;
  int scroll_count   = 0;
  int long_holds     = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d status words still expected", $time, status_due.size());
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Console behavior
  // --------------------------------------------------------------------------
  function automatic int cell_addr(int row, int col);
    return ((top_row + row) % SCREEN_ROWS) * SCREEN_COLS + col;
  endfunction

  function automatic void blank_row(int row);
    int c;
    for (c = 0; c < SCREEN_COLS; c++) screen_mem[cell_addr(row, c)] = '0;
  endfunction

  // Writes on the cursor row; a column past the row end is dropped.
  function automatic void write_cell(int col, logic [CHAR_W-1:0] v);
    if (col < SCREEN_COLS) screen_mem[cell_addr(cur_line, col)] = v;
  endfunction

  function automatic void store_cmd(int pos, logic [CHAR_W-1:0] v);
    cmd_buf[pos]     = v;
    cmd_written[pos] = 1'b1;
  endfunction

  // The bottom row scrolls the ring instead of moving the cursor.
  function automatic void advance_line();
    cur_col = 0;
    if (cur_line + 1 >= SCREEN_ROWS) begin
      top_row  = (top_row + 1) % SCREEN_ROWS;
      cur_line = SCREEN_ROWS - 1;
      scroll_count++;
    end else begin
      cur_line++;
    end
    blank_row(cur_line);
  endfunction

  function automatic void start_prompt();
    blank_row(cur_line);
    write_cell(0, CH_GT);
    write_cell(1, CH_SPACE);
    cur_col  = 2;
    edit_cnt = 0;
  endfunction

  // Applies one accepted transaction and returns the status word it must give.
  // acted is low when the transaction changes nothing and reads nothing.
  function automatic void console_predict(input logic [FUNC_W-1:0] f,
                                          input logic [CHAR_W-1:0] code,
                                          input logic [ROW_W-1:0] row,
                                          input logic [COL_W-1:0] col,
                                          input logic [BUF_AW-1:0] idx,
                                          output console_status_t st,
                                          output bit acted);
    int pad;
    st    = '0;
    acted = 1'b1;
    case (f)
      FUNC_PRINT: begin
        if (code == CH_LF || code == CH_CR) begin
          advance_line();
        end else if (code == CH_TAB) begin
          // Pad to the next tab stop but never past the row end.
          pad = TAB_STOP - cur_col % TAB_STOP;
          while (pad > 0 && cur_col < SCREEN_COLS) begin
            write_cell(cur_col, CH_SPACE);
            cur_col++;
            pad--;
          end
        end else if (code < CH_SPACE || code > CH_DEL) begin
          acted = 1'b0;
        end else begin
          // A printable byte at the row end wraps first.
          if (cur_col >= SCREEN_COLS) advance_line();
          write_cell(cur_col, code);
          cur_col++;
          write_cell(cur_col, '0);
        end
      end
      FUNC_KEY: begin
        if (code == CH_NUL || code == CH_ESC) begin
          acted = 1'b0;
        end else if (code == CH_LF || code == CH_CR) begin
          advance_line();
          if (edit_cnt > 0) begin
            st.cmd_ready = 1'b1;
            st.cmd_len   = CNT_W'(edit_cnt);
            commands_done++;
          end
          start_prompt();
        end else if (code == CH_BS || code == CH_DEL) begin
          if (edit_cnt > 0) begin
            edit_cnt--;
            store_cmd(edit_cnt, '0);
            // The cursor never moves back into the prompt.
            if (cur_col > 2) begin
              cur_col--;
              write_cell(cur_col, '0);
            end
          end else begin
            acted = 1'b0;
          end
        end else if (edit_cnt < MAX_COMMAND && cur_col + 1 < SCREEN_COLS) begin
          store_cmd(edit_cnt, code);
          edit_cnt++;
          store_cmd(edit_cnt, '0);
          write_cell(cur_col, code);
          cur_col++;
          write_cell(cur_col, '0);
        end else begin
          // Command full or line full: the key is dropped.
          acted = 1'b0;
        end
      end
      FUNC_READ_CELL: st.data = screen_mem[cell_addr(row, col)];
      FUNC_READ_CMD:  st.data = cmd_buf[idx];
      FUNC_PROMPT:    start_prompt();
      default:        acted = 1'b0;
    endcase
    st.row      = ROW_W'(cur_line);
    st.col      = CURCOL_W'(cur_col);
    st.edit_len = CNT_W'(edit_cnt);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // A key that is appended to the command: mostly printable, any other byte
  // that is not an editing key now and then.
  function automatic logic [CHAR_W-1:0] edit_key();
    logic [CHAR_W-1:0] k;
    if ($urandom_range(0, 4) != 0) return CHAR_W'($urandom_range(CH_SPACE + 1, CH_DEL - 1));
    do k = CHAR_W'($urandom_range(0, 255));
    while (k == CH_NUL || k == CH_ESC || k == CH_BS || k == CH_DEL ||
           k == CH_LF || k == CH_CR);
    return k;
  endfunction

  // A byte that printing ignores: a control code other than tab and new line,
  // or a byte with the top bit set.
  function automatic logic [CHAR_W-1:0] ignored_byte();
    logic [CHAR_W-1:0] b;
    if ($urandom_range(0, 1) != 0) return CHAR_W'($urandom_range(CH_DEL + 1, 255));
    do b = CHAR_W'($urandom_range(0, CH_SPACE - 1));
    while (b == CH_TAB || b == CH_LF || b == CH_CR);
    return b;
  endfunction

  // Command buffer entries are only read once they have been written.
  function automatic int pick_cmd_index();
    int k, n;
    for (n = 0; n < 8; n++) begin
      k = $urandom_range(0, BUF_DEPTH - 1);
      if (cmd_written[k]) return k;
    end
    for (k = 0; k < BUF_DEPTH; k++) if (cmd_written[k]) return k;
    return -1;
  endfunction

  // Offers one transaction and records its prediction once it is accepted.
  // valid stays high between transactions unless a gap is inserted.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] code,
                           input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                           input logic [BUF_AW-1:0] idx);
    console_status_t st;
    bit              acted;
    int              gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, idx, col, row, code};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    console_predict(f, code, row, col, idx, st, acted);
    status_due.push_back(st);
    items_sent++;
    if (acted) useful_count++;
  endtask

  // Same as send_item with the unused fields random. A command read takes an
  // entry that has been written, or turns into a cell read if none has.
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] code);
    logic [FUNC_W-1:0] g;
    int                idx;
    g   = f;
    idx = $urandom_range(0, BUF_DEPTH - 1);
    if (f == FUNC_READ_CMD) begin
      idx = pick_cmd_index();
      if (idx < 0) begin
        g   = FUNC_READ_CELL;
        idx = 0;
      end
    end
    send_item(g, code, $urandom_range(0, SCREEN_ROWS - 1),
              $urandom_range(0, SCREEN_COLS - 1), idx);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold when a test asks for one.
  // --------------------------------------------------------------------------
  initial begin : sink_side
    int stall;
    forever begin
      @(posedge clk);
      stall = 0;
      if (sink_hold_req > 0) begin
        stall         = sink_hold_req;
        sink_hold_req = 0;
        sink_in_hold  = 1'b1;
        long_holds++;
      end else if (sink_idle_en) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      sink_in_hold = 1'b0;
      out_tready  <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Checker
  // --------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_status(input logic [OUT_DATA_W-1:0] word);
    console_status_t got, want;
    got = console_status_t'(word[OUT_FIELDS_W-1:0]);
    if (status_due.size() == 0) begin
      $display("%0t: status word 0x%h arrived with none expected", $time, word);
      mismatch_count++;
      return;
    end
    want = status_due.pop_front();
    results_seen++;
    compare_field("read_data", want.data, got.data);
    compare_field("cursor_row", want.row, got.row);
    compare_field("cursor_col", want.col, got.col);
    compare_field("edit_length", want.edit_len, got.edit_len);
    compare_field("command_ready", want.cmd_ready, got.cmd_ready);
    compare_field("command_length", want.cmd_len, got.cmd_len);
    compare_field("tdata pad", '0, word[OUT_DATA_W-1:OUT_FIELDS_W]);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) check_status(out_tdata);
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset contents, printing edges, ignored bytes and keys, the editing keys
  // and the spare function codes.
  task automatic test_directed();
    send_item(FUNC_READ_CELL, $urandom, 0, 0, $urandom);
    send_item(FUNC_READ_CELL, $urandom, SCREEN_ROWS - 1, SCREEN_COLS - 1, $urandom);
    send_op(FUNC_PRINT, CH_SPACE);
    send_op(FUNC_PRINT, CH_DEL);
    send_op(FUNC_PRINT, CH_SPACE - 8'd1);
    send_op(FUNC_PRINT, CH_DEL + 8'd1);
    send_op(FUNC_PRINT, 8'hFF);
    send_op(FUNC_PRINT, CH_NUL);
    send_op(FUNC_PRINT, CH_TAB);
    send_op(FUNC_PRINT, CH_CR);
    send_op(FUNC_PRINT, CH_LF);
    send_op(FUNC_KEY, CH_NUL);
    send_op(FUNC_KEY, CH_ESC);
    send_op(FUNC_KEY, CH_BS);          // nothing to erase yet
    send_op(FUNC_KEY, CH_LF);          // Enter on an empty line
    send_op(FUNC_KEY, 8'h61);
    send_op(FUNC_KEY, 8'hFF);
    send_item(FUNC_READ_CMD, $urandom, $urandom, $urandom, 0);
    send_item(FUNC_READ_CMD, $urandom, $urandom, $urandom, 1);
    send_op(FUNC_KEY, CH_DEL);
    send_op(FUNC_KEY, CH_CR);          // submits a one-byte command
    send_op(FUNC_PROMPT, $urandom);
    send_op(FUNC_SPARE_LO, $urandom);
    send_op(FUNC_SPARE_HI, $urandom);
    send_item(FUNC_READ_CELL, $urandom, cur_line, 0, $urandom);
  endtask

  // Fills the command to its maximum across several lines (a printed new line
  // keeps the command but frees the row), hits both the line limit and the
  // length limit, reads back every written buffer entry and submits it.
  task automatic test_long_command();
    int i;
    send_op(FUNC_PROMPT, $urandom);
    send_op(FUNC_PRINT, CH_LF);
    while (edit_cnt < MAX_COMMAND) begin
      if (cur_col + 1 < SCREEN_COLS) begin
        send_op(FUNC_KEY, edit_key());
      end else begin
        send_op(FUNC_KEY, edit_key());
        send_op(FUNC_PRINT, CH_CR);
      end
    end
    send_op(FUNC_KEY, edit_key());
    for (i = 0; i < BUF_DEPTH; i++)
      if (cmd_written[i]) send_item(FUNC_READ_CMD, $urandom, $urandom, $urandom, i);
    send_op(FUNC_KEY, CH_CR);
  endtask

  // The receiver holds off for a long time while items keep coming, so the
  // output register fills and the input side has to stall.
  task automatic test_backpressure();
    int n;
    src_idle_en   = 1'b0;
    sink_hold_req = 400;
    in_tvalid    <= 1'b0;
    while (!sink_in_hold) @(posedge clk);
    for (n = 0; n < 12; n++) begin
      if (n % 3 == 0) send_op(FUNC_READ_CELL, $urandom);
      else            send_op(FUNC_PRINT, $urandom_range(CH_SPACE, CH_DEL));
    end
    src_idle_en = 1'b1;
  endtask

  // A prompt, a typed command with corrections and read-backs, then Enter.
  task automatic test_command_session();
    int len, r;
    send_op(FUNC_PROMPT, $urandom);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70) : $urandom_range(1, 12);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 78)      send_op(FUNC_KEY, edit_key());
      else if (r < 88) send_op(FUNC_KEY, $urandom_range(0, 1) ? CH_BS : CH_DEL);
      else if (r < 93) send_op(FUNC_READ_CMD, $urandom);
      else if (r < 97) send_item(FUNC_READ_CELL, $urandom, cur_line,
                                 $urandom_range(0, SCREEN_COLS - 1), $urandom);
      else             send_op(FUNC_KEY, $urandom_range(0, 1) ? CH_NUL : CH_ESC);
    end
    send_op(FUNC_KEY, $urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  // Printed text: mostly printable bytes, with tabs, new lines, ignored bytes
  // and cell reads. Long runs wrap at the row end.
  task automatic test_print_text();
    int len, r;
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 150) : $urandom_range(5, 40);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 70)      send_op(FUNC_PRINT, $urandom_range(CH_SPACE, CH_DEL));
      else if (r < 78) send_op(FUNC_PRINT, CH_TAB);
      else if (r < 86) send_op(FUNC_PRINT, $urandom_range(0, 1) ? CH_CR : CH_LF);
      else if (r < 93) send_op(FUNC_PRINT, ignored_byte());
      else             send_op(FUNC_READ_CELL, $urandom);
    end
  endtask

  // Any function code with any byte.
  task automatic test_random_noise();
    repeat (20) send_op($urandom_range(0, FUNC_SPARE_HI), $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_long_command();
    test_backpressure();

    // Random part. Some phases run without any idling on one or both sides.
    while (items_sent < TOTAL_ITEMS) begin
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: test_command_session();
        5, 6, 7:       test_print_text();
        default:       test_random_noise();
      endcase
    end
    in_tvalid <= 1'b0;
    sink_idle_en = 1'b1;

    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d transactions (%0d with an effect), checked %0d status words, %0d mismatches.",
             items_sent, useful_count, results_seen, mismatch_count);
    $display("Submitted %0d commands, scrolled %0d times, %0d long receiver hold(s).",
             commands_done, scroll_count, long_holds);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tcle_pkg.sv
rtl/core/tcle_datapath.sv
rtl/core/tcle_ctrl.sv
rtl/core/text_console_line_editor.sv
rtl/core/tcle_checker.sv
tb/text_console_line_editor_tb.sv
